/* rtl/core/lkv_pkg.sv */
`timescale 1ns / 1ps

package lkv_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int DATA_W  = 32;
   localparam int CAP_W   = 5;
   localparam int ADDR_W  = 3;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   localparam logic [ADDR_W-1:0] REG_CAPACITY   = ADDR_W'(0);
   localparam logic [CAP_W-1:0]  CAPACITY_RESET = CAP_W'(ENTRIES);

   // lookup broadcast to every cell
   typedef struct packed {
      logic [DATA_W-1:0] key;
      logic [CNT_W-1:0]  used;
   } look_type;

   // update broadcast to every cell
   typedef struct packed {
      logic              enable;
      logic              wr;
      logic [IDX_W-1:0]  target;
      logic [CNT_W-1:0]  thr;
      logic [DATA_W-1:0] value;
   } update_type;

   // result carried from cell to cell
   typedef struct packed {
      logic              found;
      logic [IDX_W-1:0]  hit_idx;
      logic [IDX_W-1:0]  hit_rank;
      logic [DATA_W-1:0] hit_value;
      logic [IDX_W-1:0]  vic_idx;
      logic [DATA_W-1:0] vic_key;
   } chain_type;

endpackage

/* rtl/core/lkv_cell.sv */
`timescale 1ns / 1ps

module lkv_cell (
   input  logic                       clock,
   input  logic [lkv_pkg::IDX_W-1:0]  idx,
   input  lkv_pkg::look_type          look,
   input  lkv_pkg::update_type        upd,
   input  lkv_pkg::chain_type         chain_i,
   output lkv_pkg::chain_type         chain_o
);

   logic [lkv_pkg::DATA_W-1:0] key_ff, key_in;
   logic [lkv_pkg::DATA_W-1:0] value_ff, value_in;
   logic [lkv_pkg::IDX_W-1:0]  rank_ff, rank_in;
   logic                       valid;
   logic                       match;
   logic                       victim;

   always_comb begin
      valid  = {1'b0, idx} < look.used;
      match  = valid && (key_ff == look.key);
      victim = valid && ({1'b0, rank_ff} == (look.used - lkv_pkg::CNT_W'(1)));

      chain_o = chain_i;
      if (match && !chain_i.found) begin
         chain_o.found     = 1'b1;
         chain_o.hit_idx   = idx;
         chain_o.hit_rank  = rank_ff;
         chain_o.hit_value = value_ff;
      end
      if (victim) begin
         chain_o.vic_idx = idx;
         chain_o.vic_key = key_ff;
      end

      key_in   = key_ff;
      value_in = value_ff;
      rank_in  = rank_ff;
      if (upd.enable) begin
         if (idx == upd.target) begin
            rank_in = '0;
            if (upd.wr) begin
               key_in   = look.key;
               value_in = upd.value;
            end
         end else if (valid && ({1'b0, rank_ff} < upd.thr)) begin
            rank_in = rank_ff + lkv_pkg::IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      rank_ff  <= rank_in;
   end

endmodule

/* rtl/core/lru_key_value_cache.sv */
`timescale 1ns / 1ps

// Fully associative key/value cache with least-recently-used replacement.
// Request channel (req_*): operation (0 get, 1 put), key, value. A word is
// taken on a clock edge with req_valid high and req_stall low.
// Response channel (rsp_*): hit, read_value, evicted, evicted_key; one
// response word per request, in order, taken when rsp_valid is high and
// rsp_stall is low.
// CSR port (csr_*): one register, capacity, at address 0 (5 bits,
// reset 16; 0 acts as 1, above 16 acts as 16). Write only while idle.
// The request word is registered first; when the response register is free,
// the key compare and recency update run along the row of 16 entry cells
// and load the response register. A new request is not taken until the
// held one has been run. req_stall is high while a request is held. While a
// finished response waits under rsp_stall, one more request can be taken; it
// is held until the response register frees.
// Reset (synchronous): empties the cache and sets capacity to 16; no
// clearing pass, the block is ready in the next cycle.

module lru_key_value_cache (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_operation,
   input  logic signed [31:0]           req_key,
   input  logic signed [31:0]           req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit,
   output logic signed [31:0]           rsp_read_value,
   output logic                         rsp_evicted,
   output logic signed [31:0]           rsp_evicted_key,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [lkv_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   logic                        busy_ff, busy_in;
   logic                        op_ff, op_in;
   logic [lkv_pkg::DATA_W-1:0]  key_ff, key_in;
   logic [lkv_pkg::DATA_W-1:0]  value_ff, value_in;
   logic [lkv_pkg::CNT_W-1:0]   used_ff, used_in;
   logic [lkv_pkg::CAP_W-1:0]   cap_ff, cap_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        hit_ff, hit_in;
   logic [lkv_pkg::DATA_W-1:0]  rdata_ff, rdata_in;
   logic                        evicted_ff, evicted_in;
   logic [lkv_pkg::DATA_W-1:0]  evkey_ff, evkey_in;

   lkv_pkg::look_type           look;
   lkv_pkg::update_type         upd;
   lkv_pkg::chain_type          chain [lkv_pkg::ENTRIES+1];
   lkv_pkg::chain_type          res;

   logic                        accept;
   logic                        exec;
   logic                        cfg_wr;
   logic [lkv_pkg::CAP_W-1:0]   eff_cap;
   logic                        room;
   logic                        is_put;

   assign chain[0] = '0;
   assign res      = chain[lkv_pkg::ENTRIES];

   for (genvar i = 0; i < lkv_pkg::ENTRIES; i++) begin : g_cell
      lkv_cell u_cell (
         .clock   (clock),
         .idx     (lkv_pkg::IDX_W'(i)),
         .look    (look),
         .upd     (upd),
         .chain_i (chain[i]),
         .chain_o (chain[i+1])
      );
   end

   always_comb begin
      accept = req_valid && !req_stall;
      exec   = busy_ff && (!rsp_valid_ff || !rsp_stall);
      cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
      is_put = op_ff == lkv_pkg::OP_PUT;

      if (cap_ff == '0) begin
         eff_cap = lkv_pkg::CAP_W'(1);
      end else if (cap_ff > lkv_pkg::CAP_W'(lkv_pkg::ENTRIES)) begin
         eff_cap = lkv_pkg::CAP_W'(lkv_pkg::ENTRIES);
      end else begin
         eff_cap = cap_ff;
      end
      room = lkv_pkg::CAP_W'(used_ff) < eff_cap;

      look.key  = key_ff;
      look.used = used_ff;

      upd.enable = exec && (res.found || is_put);
      upd.wr     = is_put;
      upd.value  = value_ff;
      if (res.found) begin
         upd.target = res.hit_idx;
         upd.thr    = {1'b0, res.hit_rank};
      end else if (room) begin
         upd.target = used_ff[lkv_pkg::IDX_W-1:0];
         upd.thr    = used_ff;
      end else begin
         upd.target = res.vic_idx;
         upd.thr    = used_ff;
      end

      busy_in  = busy_ff;
      op_in    = op_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (accept) begin
         busy_in  = 1'b1;
         op_in    = req_operation;
         key_in   = req_key;
         value_in = req_value;
      end else if (exec) begin
         busy_in = 1'b0;
      end

      used_in = used_ff;
      if (exec && is_put && !res.found && room) begin
         used_in = used_ff + lkv_pkg::CNT_W'(1);
      end

      cap_in = cap_ff;
      if (cfg_wr && csr_paddr == lkv_pkg::REG_CAPACITY) begin
         cap_in = csr_pwdata[lkv_pkg::CAP_W-1:0];
      end

      rsp_valid_in = exec || (rsp_valid_ff && rsp_stall);
      hit_in       = hit_ff;
      rdata_in     = rdata_ff;
      evicted_in   = evicted_ff;
      evkey_in     = evkey_ff;
      if (exec) begin
         hit_in     = res.found;
         evicted_in = is_put && !res.found && !room;
         evkey_in   = (is_put && !res.found && !room) ? res.vic_key : '0;
         if (is_put) begin
            rdata_in = '0;
         end else if (res.found) begin
            rdata_in = res.hit_value;
         end else begin
            rdata_in = '1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         used_ff      <= '0;
         cap_ff       <= lkv_pkg::CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         used_ff      <= used_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      value_ff   <= value_in;
      hit_ff     <= hit_in;
      rdata_ff   <= rdata_in;
      evicted_ff <= evicted_in;
      evkey_ff   <= evkey_in;
   end

   assign req_stall       = busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_read_value  = rdata_ff;
   assign rsp_evicted     = evicted_ff;
   assign rsp_evicted_key = evkey_ff;
   assign csr_pready      = 1'b1;
   assign csr_prdata      = (csr_paddr == lkv_pkg::REG_CAPACITY) ?
                            {{(32 - lkv_pkg::CAP_W){1'b0}}, cap_ff} : '0;

endmodule
